FILE: sv/clra_pkg.sv
// ----------------------------------------------------------------------------
// clra_pkg
// Shared types and codes for the checkpoint log ring allocator.
// ----------------------------------------------------------------------------
package clra_pkg;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_COMMIT = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [0:0] REG_LOG_BYTES    = 1'd0;
  localparam logic [0:0] REG_HEADER_BYTES = 1'd1;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] version;
    logic [31:0] size;
    logic [31:0] start;
    logic [31:0] last;
  } slot_t;

endpackage

FILE: sv/checkpoint_log_ring_allocator_top.sv
// ----------------------------------------------------------------------------
// checkpoint_log_ring_allocator_top
// Circular log space allocator over a ring of checkpoint slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*) carries one request per transfer: write, commit or
//   read. Result channel (out_*) returns one result per request.
//   Slot records live in one RAM with a registered read.
//   Write: reads the newest slot (data head) and the oldest slot (data
//   tail), then places the region; the tail read is skipped when the slot
//   ring is full.
//   Commit: reads and retires slots from the tail while their version is
//   below the request's, stopping at the head or when nothing was written.
//   Read: searches slots from the newest back to the tail; no search when
//   the ring is empty.
//   One request is in flight at a time. The next request is taken at the
//   earliest at the edge where the result transfers; while the receiver
//   stalls, the result holds and input acceptance is blocked.
//   Reset (rst_n low, synchronous) empties the ring and restores
//   log_bytes = 1048576 and header_bytes = 8; slot RAM is not cleared.
//   Configuration: APB-style writes at cfg_paddr 0 (log_bytes) and
//   4 (header_bytes); always ready.
// ----------------------------------------------------------------------------
module checkpoint_log_ring_allocator_top
  import clra_pkg::*;
#(
  parameter int SLOTS     = 64,
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_key_tag,
  input  logic [31:0] in_version,
  input  logic [31:0] in_data_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot_index,
  output logic [31:0] out_region_first,
  output logic [31:0] out_region_last,
  output logic [31:0] out_stored_size,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam logic [63:0] KMASK = (KEY_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                  ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WRD1   = 4'd1;
  localparam logic [3:0] S_WRD2   = 4'd2;
  localparam logic [3:0] S_WCALC  = 4'd3;
  localparam logic [3:0] S_CRD    = 4'd4;
  localparam logic [3:0] S_CCHK   = 4'd5;
  localparam logic [3:0] S_RRD    = 4'd6;
  localparam logic [3:0] S_RCHK   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [31:0]   log_bytes_r;
  logic [7:0]    hdr_r;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt, idx_r, idx_nxt;
  logic          started_r, started_nxt;
  logic [63:0]   key_r;
  logic [31:0]   ver_r, size_r;
  logic [32:0]   dhead_r, dhead_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    o_st_r, o_st_nxt;
  logic [5:0]    o_slot_r, o_slot_nxt;
  logic [31:0]   o_s_r, o_s_nxt, o_e_r, o_e_nxt, o_sz_r, o_sz_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_t         wdata, rdata;

  clra_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction
  function automatic logic [AW-1:0] prv(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - AW'(1);
  endfunction

  // config
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    if (cfg_paddr[2] == REG_HEADER_BYTES) begin
      cfg_prdata = {24'd0, hdr_r};
    end else begin
      cfg_prdata = log_bytes_r;
    end
  end

  logic in_acc;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // write computations
  logic [32:0] need, dtail, avail, at;
  logic        empty, wfit;
  always_comb begin
    need  = 33'(size_r) + 33'(hdr_r);
    if (need == '0) need = 33'd1;
    empty = !started_r || (head_r == tail_r);
    dtail = empty ? dhead_r : {1'b0, rdata.start};
    avail = (dhead_r <= {1'b0, log_bytes_r}) ? {1'b0, log_bytes_r} - dhead_r : '0;
    wfit  = 1'b0;
    at    = dhead_r;
    if (!empty && dhead_r == dtail) begin
      wfit = 1'b0;
    end else if (dhead_r >= dtail) begin
      if (avail >= need) begin
        wfit = 1'b1;
      end else if (dtail >= need) begin
        wfit = 1'b1;
        at   = '0;
      end
    end else if (dtail - dhead_r >= need) begin
      wfit = 1'b1;
    end
  end

  logic [32:0] wend;
  assign wend = at + need - 33'd1;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    idx_nxt       = idx_r;
    started_nxt   = started_r;
    dhead_nxt     = dhead_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_st_nxt      = o_st_r;
    o_slot_nxt    = o_slot_r;
    o_s_nxt       = o_s_r;
    o_e_nxt       = o_e_r;
    o_sz_nxt      = o_sz_r;
    we            = 1'b0;
    waddr         = head_r;
    wdata         = '{key: key_r & KMASK, version: ver_r, size: size_r,
                      start: at[31:0], last: wend[31:0]};
    raddr         = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          o_st_nxt = ST_OK; o_slot_nxt = '0; o_s_nxt = '0; o_e_nxt = '0; o_sz_nxt = '0;
          case (in_req_type)
            REQ_WRITE: begin
              state_nxt = S_WRD1;
            end
            REQ_COMMIT: begin
              state_nxt = S_CRD;
            end
            REQ_READ: begin
              idx_nxt   = prv(head_r);
              state_nxt = S_RRD;
              if (!started_r || head_r == tail_r) begin
                o_st_nxt  = ST_EMPTY;
                state_nxt = S_OUT;
              end
            end
            default: begin
              o_st_nxt  = ST_NOTFOUND;
              state_nxt = S_OUT;
            end
          endcase
          if (in_req_type == REQ_WRITE || in_req_type == REQ_COMMIT) begin
            idx_nxt = (in_req_type == REQ_WRITE) ? prv(head_r) : tail_r;
          end
        end
      end
      S_WRD1: begin
        raddr     = idx_r;
        idx_nxt   = tail_r;
        state_nxt = S_WRD2;
        if (started_r && nxt(head_r) == tail_r) begin
          o_st_nxt  = ST_NOSPACE;
          state_nxt = S_OUT;
        end
      end
      S_WRD2: begin
        raddr     = idx_r;
        dhead_nxt = started_r ? {1'b0, rdata.last} + 33'd1 : '0;
        state_nxt = S_WCALC;
      end
      S_WCALC: begin
        state_nxt = S_OUT;
        if (wfit) begin
          we          = 1'b1;
          waddr       = started_r ? head_r : '0;
          head_nxt    = started_r ? nxt(head_r) : AW'(1);
          if (!started_r) tail_nxt = '0;
          started_nxt = 1'b1;
          o_slot_nxt  = 6'(started_r ? head_r : '0);
          o_s_nxt     = at[31:0];
          o_e_nxt     = wend[31:0];
          o_sz_nxt    = size_r;
        end else begin
          o_st_nxt = ST_NOSPACE;
        end
      end
      S_CRD: begin
        raddr     = idx_r;
        state_nxt = S_CCHK;
        if (!started_r || tail_r == head_r) begin
          o_slot_nxt = 6'(tail_r);
          state_nxt  = S_OUT;
        end
      end
      S_CCHK: begin
        if (rdata.version < ver_r) begin
          tail_nxt  = nxt(tail_r);
          idx_nxt   = nxt(tail_r);
          state_nxt = S_CRD;
        end else begin
          o_slot_nxt = 6'(tail_r);
          state_nxt  = S_OUT;
        end
      end
      S_RRD: begin
        raddr     = idx_r;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (rdata.key == (key_r & KMASK) && rdata.version == ver_r) begin
          o_slot_nxt = 6'(idx_r);
          o_s_nxt    = rdata.start;
          o_e_nxt    = rdata.last;
          o_sz_nxt   = rdata.size;
          state_nxt  = S_OUT;
        end else if (idx_r == tail_r) begin
          o_st_nxt  = ST_NOTFOUND;
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = prv(idx_r);
          state_nxt = S_RRD;
        end
      end
      S_OUT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      log_bytes_r <= 32'd1048576;
      hdr_r       <= 8'd8;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_LOG_BYTES) log_bytes_r <= cfg_pwdata;
      if (cfg_wr && cfg_paddr[2] == REG_HEADER_BYTES) hdr_r <= cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    dhead_r  <= dhead_nxt;
    o_st_r   <= o_st_nxt;
    o_slot_r <= o_slot_nxt;
    o_s_r    <= o_s_nxt;
    o_e_r    <= o_e_nxt;
    o_sz_r   <= o_sz_nxt;
    if (in_acc) begin
      key_r  <= in_key_tag;
      ver_r  <= in_version;
      size_r <= in_data_size;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_st_r;
  assign out_slot_index   = o_slot_r;
  assign out_region_first = o_s_r;
  assign out_region_last  = o_e_r;
  assign out_stored_size  = o_sz_r;

endmodule

FILE: sv/clra_ram.sv
// ----------------------------------------------------------------------------
// clra_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module clra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: verif/tb_checkpoint_log_ring_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checkpoint_log_ring_allocator_top
// Self-checking bench for the checkpoint log ring allocator: a directed table
// (reset state, extremes, commit, lookup, error codes), wrap and full ring
// under a small log, and a random mix of write/commit/read sequences, all
// scored against an in-bench allocator model. Bursty sender, patterned
// receiver stalls, and one long receiver hold-off to back up the input.
// ----------------------------------------------------------------------------
module tb_checkpoint_log_ring_allocator_top;
  import clra_pkg::*;

  localparam int NSLOT = 64;
  localparam int WATCHDOG = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_LOG_BYTES = 3'(4 * REG_LOG_BYTES);
  localparam logic [2:0] ADDR_HEADER_BYTES = 3'(4 * REG_HEADER_BYTES);

  typedef struct packed {
    logic [1:0]  req;
    logic [63:0] key;
    logic [31:0] ver;
    logic [31:0] size;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] start;
    logic [31:0] last;
    logic [31:0] size;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [63:0] in_key_tag = '0;
  logic [31:0] in_version = '0;
  logic [31:0] in_data_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_slot_index;
  logic [31:0] out_region_first, out_region_last, out_stored_size;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  checkpoint_log_ring_allocator_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator model state
  logic [63:0] m_key  [NSLOT];
  logic [31:0] m_ver  [NSLOT];
  logic [31:0] m_size [NSLOT];
  logic [31:0] m_start[NSLOT];
  logic [31:0] m_end  [NSLOT];
  logic [5:0]  m_head, m_tail;
  bit          m_started;
  logic [31:0] m_log_bytes;
  logic [7:0]  m_hdr_bytes;

  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit stall_en = 1'b1;

  function automatic result_t alloc_predict(request_t r);
    result_t o;
    logic [33:0] need, dhead, dtail, avail, at;
    bit empty;
    logic [5:0] i;
    o = '0;
    case (r.req)
      REQ_WRITE: begin
        need = 34'(r.size) + 34'(m_hdr_bytes);
        if (need == 0) need = 1;
        empty = !m_started || m_head == m_tail;
        o.status = ST_NOSPACE;
        if (m_started && 6'(m_head + 1) == m_tail) return o;
        if (!m_started) begin
          dhead = 0;
          dtail = 0;
        end else begin
          dhead = 34'(m_end[6'(m_head - 1)]) + 1;
          dtail = empty ? dhead : 34'(m_start[m_tail]);
        end
        if (!empty && dhead == dtail) return o;
        if (dhead >= dtail) begin
          avail = (dhead <= 34'(m_log_bytes)) ? 34'(m_log_bytes) - dhead : 0;
          if (avail >= need) at = dhead;
          else if (dtail >= need) at = 0;
          else return o;
        end else begin
          if (dtail - dhead >= need) at = dhead;
          else return o;
        end
        if (!m_started) begin
          m_head = 0;
          m_tail = 0;
          m_started = 1'b1;
        end
        m_key[m_head] = r.key;
        m_ver[m_head] = r.ver;
        m_size[m_head] = r.size;
        m_start[m_head] = 32'(at);
        m_end[m_head] = 32'(at + need - 1);
        o = '{ST_OK, m_head, m_start[m_head], m_end[m_head], r.size};
        m_head = m_head + 1;
      end
      REQ_COMMIT: begin
        if (m_started)
          while (m_tail != m_head && m_ver[m_tail] < r.ver) m_tail = m_tail + 1;
        o.status = ST_OK;
        o.slot = m_tail;
      end
      REQ_READ: begin
        o.status = ST_EMPTY;
        if (!m_started || m_head == m_tail) return o;
        o.status = ST_NOTFOUND;
        i = m_head;
        do begin
          i = i - 1;
          if (m_key[i] == r.key && m_ver[i] == r.ver)
            return '{ST_OK, i, m_start[i], m_end[i], m_size[i]};
        end while (i != m_tail);
      end
      default: o.status = ST_NOTFOUND;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s at %0t", msg, $time);
    errors++;
  endtask

  // result checking
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer");
      end else begin
        want = expected_results.pop_front();
        if (out_status != want.status)
          report_mismatch($sformatf("status: got %0h expected %0h", out_status, want.status));
        if (out_slot_index != want.slot)
          report_mismatch($sformatf("slot_index: got %0h expected %0h",
                                    out_slot_index, want.slot));
        if (out_region_first != want.start)
          report_mismatch($sformatf("region_first: got %0h expected %0h",
                                    out_region_first, want.start));
        if (out_region_last != want.last)
          report_mismatch($sformatf("region_last: got %0h expected %0h",
                                    out_region_last, want.last));
        if (out_stored_size != want.size)
          report_mismatch($sformatf("stored_size: got %0h expected %0h",
                                    out_stored_size, want.size));
      end
    end
  end

  // receiver stall pattern plus one long hold-off
  always @(negedge clk) begin
    int ph;
    ph = int'(($time / 10) % 23);
    if (long_hold) out_stall <= 1'b1;
    else if (!stall_en) out_stall <= 1'b0;
    else out_stall <= (ph < 5) || ($urandom_range(0, 7) == 0);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_LOG_BYTES) m_log_bytes = data;
    else m_hdr_bytes = data[7:0];
  endtask

  task automatic drain;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2 * NSLOT + 20) @(negedge clk);
  endtask

  // one transfer; valid stays up when the next call follows at once
  task automatic send_request(request_t r, bit typed, result_t res);
    result_t p;
    in_valid <= 1'b1;
    in_req_type <= r.req;
    in_key_tag <= r.key;
    in_version <= r.ver;
    in_data_size <= r.size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = alloc_predict(r);
    if (typed && p != res) report_mismatch("table row disagrees with model");
    expected_results.push_back(p);
    @(negedge clk);
  endtask

  task automatic gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_size(int mode);
    case (mode)
      0: return $urandom_range(0, 64);
      1: return $urandom_range(0, 4096);
      2: return $urandom;
      default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  table_row_t dir_table[$];
  logic [63:0] keys[8];

  task automatic add_row(logic [1:0] q, logic [63:0] k, logic [31:0] v,
                         logic [31:0] s, bit typed, result_t res);
    dir_table.push_back('{'{q, k, v, s}, typed, res});
  endtask

  initial begin
    request_t r;
    int burst, sent, sel, len;
    for (int i = 0; i < 8; i++) keys[i] = {$urandom, $urandom};
    m_head = 0; m_tail = 0; m_started = 0;
    m_log_bytes = 32'd1048576; m_hdr_bytes = 8'd8;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    add_row(REQ_READ,   64'h1, 1, 0, 1, '{ST_EMPTY, 0, 0, 0, 0});
    add_row(REQ_COMMIT, 0, 5, 0, 1, '{ST_OK, 0, 0, 0, 0});
    add_row(REQ_UNUSED, '1, '1, '1, 1, '{ST_NOTFOUND, 0, 0, 0, 0});
    add_row(REQ_WRITE,  '1, '1, '1, 1, '{ST_NOSPACE, 0, 0, 0, 0});
    add_row(REQ_WRITE,  64'hA, 1, 0, 1, '{ST_OK, 0, 0, 7, 0});
    add_row(REQ_WRITE,  0, 0, 100, 1, '{ST_OK, 1, 8, 115, 100});
    add_row(REQ_WRITE,  '1, '1, 1048560, 0, '0);
    add_row(REQ_READ,   64'hA, 1, 0, 1, '{ST_OK, 0, 0, 7, 0});
    add_row(REQ_READ,   64'hA, 2, 0, 1, '{ST_NOTFOUND, 0, 0, 0, 0});
    add_row(REQ_READ,   '1, '1, 0, 0, '0);
    add_row(REQ_COMMIT, 0, 1, 0, 0, '0);
    add_row(REQ_COMMIT, 0, '1, 0, 0, '0);
    add_row(REQ_READ,   64'hA, 1, 0, 0, '0);
    add_row(REQ_WRITE,  64'hB, 3, 50, 0, '0);
    add_row(REQ_COMMIT, 0, 0, 0, 0, '0);
    foreach (dir_table[i]) begin
      send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].res);
      if ($urandom_range(0, 2) == 0) gap($urandom_range(1, 4));
    end
    gap(1);
    drain();

    // zero-length reservation, wrap and full ring under a small log
    cfg_write(ADDR_HEADER_BYTES, 0);
    cfg_write(ADDR_LOG_BYTES, 200);
    r = '{REQ_COMMIT, 0, 32'hFFFF_FFFF, 0};
    send_request(r, 0, '0);
    r = '{REQ_WRITE, 64'h5, 7, 0};
    send_request(r, 0, '0);
    for (int i = 0; i < 70; i++) begin
      r = '{REQ_WRITE, keys[i % 8], 32'(i), 32'($urandom_range(0, 3))};
      send_request(r, 0, '0);
    end
    gap(1);
    drain();

    // long receiver hold-off with the sender still offering
    long_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) begin
        r = '{REQ_READ, keys[i % 8], 32'(i), 0};
        send_request(r, 0, '0);
      end
    join
    gap(1);
    drain();

    // random phases over several settings
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          cfg_write(ADDR_LOG_BYTES, 32'hFFFF_FFFF);
          cfg_write(ADDR_HEADER_BYTES, 255);
        end
        1: begin
          cfg_write(ADDR_LOG_BYTES, 1);
          cfg_write(ADDR_HEADER_BYTES, 0);
        end
        2: begin
          cfg_write(ADDR_LOG_BYTES, 4096);
          cfg_write(ADDR_HEADER_BYTES, 8);
        end
        3: begin
          cfg_write(ADDR_LOG_BYTES, $urandom_range(1, 100000));
          cfg_write(ADDR_HEADER_BYTES, $urandom_range(0, 255));
        end
        4: begin
          cfg_write(ADDR_LOG_BYTES, 600);
          cfg_write(ADDR_HEADER_BYTES, 16);
        end
        default: begin
          cfg_write(ADDR_LOG_BYTES, 1048576);
          cfg_write(ADDR_HEADER_BYTES, 8);
        end
      endcase
      stall_en = (phase != 3);
      while (sent < (phase + 1) * 130) begin
        burst = $urandom_range(1, 12);
        len = $urandom_range(0, 3);
        for (int b = 0; b < burst; b++) begin
          sel = $urandom_range(0, 99);
          if (sel < 50) begin
            r = '{REQ_WRITE, keys[$urandom_range(0, 7)], $urandom_range(0, 15),
                  rand_size((sel < 40) ? (phase == 0 ? 1 : 0) : $urandom_range(0, 3))};
          end else if (sel < 62) begin
            r = '{REQ_COMMIT, {$urandom, $urandom}, $urandom_range(0, 16), $urandom};
            if (sel == 61) r.ver = $urandom;
          end else if (sel < 94) begin
            r = '{REQ_READ, keys[$urandom_range(0, 7)], $urandom_range(0, 15), $urandom};
            if (sel == 93) r.key = {$urandom, $urandom};
          end else begin
            r = '{2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom, $urandom};
          end
          send_request(r, 0, '0);
          sent++;
        end
        if (len != 0) gap($urandom_range(1, 20));
      end
      gap(1);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
